// ===== rtl/time_ordered_event_queue_core_macros.svh =====
// Assertion macros for the time-ordered event queue.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef TIME_ORDERED_EVENT_QUEUE_CORE_MACROS_SVH
`define TIME_ORDERED_EVENT_QUEUE_CORE_MACROS_SVH

`ifndef SYNTH
`define TOEQ_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("toeq check failed");
`define TOEQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("toeq check failed");
`else
`define TOEQ_ASSERT(name, clk, rst_n, prop)
`define TOEQ_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/toeq_pkg.sv =====
// Shared types, constants and a ring index helper for the event queue.
// Used by every module of the block but toeq_ram; depends on nothing.
package toeq_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NUM_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned TYPE_W      = 5;
  localparam int unsigned TIME_W      = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 3'd0,
    CMD_REMOVE  = 3'd1,
    CMD_FIND    = 3'd2,
    CMD_POP     = 3'd3,
    CMD_ADVANCE = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_FIND  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_SCAN,
    ST_ADD_WR,
    ST_SRCH,
    ST_DEL,
    ST_POP_OUT,
    ST_ADV_RD,
    ST_ADV_CHK,
    ST_ADV_END,
    ST_REPLY
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TYPE_W-1:0] event_type;
    logic [TIME_W-1:0] event_time;
    logic [TIME_W-1:0] target_time;
  } in_word_t;

  typedef struct packed {
    kind_e             reply_kind;
    logic [TYPE_W-1:0] out_type;
    logic [TIME_W-1:0] out_time;
    logic              found;
    logic              dropped;
    logic              last;
  } out_word_t;

  typedef struct packed {
    logic [TYPE_W-1:0] etype;
    logic [TIME_W-1:0] etime;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Map a queue position to its ring slot.
  function automatic logic [IDX_W-1:0] ring_addr(logic [IDX_W-1:0] head,
                                                  logic [IDX_W-1:0] offs);
    logic [IDX_W:0] sum;
    sum = {1'b0, head} + {1'b0, offs};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

// ===== rtl/toeq_ram.sv =====
// Generic one-write, one-read synchronous RAM with registered read data.
// Stand-alone; holds the queue entries of the event queue.
module toeq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/toeq_out_reg.sv =====
// Output register of the event queue: holds one result word under stall.
// Depends on toeq_pkg for the result word type.
module toeq_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                emit_i,
  input  toeq_pkg::out_word_t word_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output toeq_pkg::out_word_t out_word_o,
  output logic                slot_free_o
);

  logic                valid_q, valid_d;
  toeq_pkg::out_word_t word_q;

  assign slot_free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (slot_free_o) begin
      valid_d = emit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free_o && emit_i) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

// ===== rtl/toeq_ctrl.sv =====
// Command sequencer of the event queue: ring head, fill count, current time,
// and the read-modify-write walks over the entry RAM. Depends on toeq_pkg.
`include "time_ordered_event_queue_core_macros.svh"

module toeq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  toeq_pkg::in_word_t  in_word_i,
  input  logic                slot_free_i,
  output logic                emit_o,
  output toeq_pkg::out_word_t emit_word_o,
  output toeq_pkg::mem_req_t  mem_req_o,
  input  toeq_pkg::entry_t    rd_entry_i
);

  localparam int unsigned IW = toeq_pkg::IDX_W;
  localparam int unsigned CW = toeq_pkg::CNT_W;
  localparam int unsigned NW = toeq_pkg::NUM_W;

  toeq_pkg::state_e    state_q, state_d;
  toeq_pkg::in_word_t  word_q, word_d;
  toeq_pkg::out_word_t rep_q, rep_d;
  logic [IW-1:0]       head_q, head_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [CW-1:0]       count_q, count_d;
  logic [NW-1:0]       num_q, num_d;
  logic                pend_v_q, pend_v_d;
  logic [toeq_pkg::TIME_W-1:0] cur_time_q, cur_time_d;

  toeq_pkg::mem_req_t  mem_req;
  logic                emit;
  toeq_pkg::out_word_t emit_word;

  logic          is_full, is_empty, srch_last, del_last, type_hit, add_later, adv_due;
  logic          adv_more;
  logic [CW-1:0] idx_cnt, count_m1;
  toeq_pkg::cmd_e cmd;

  assign cmd       = toeq_pkg::cmd_e'(word_q.cmd);
  assign idx_cnt   = CW'(idx_q);
  assign count_m1  = count_q - CW'(1);
  assign is_full   = (count_q == CW'(toeq_pkg::QUEUE_DEPTH));
  assign is_empty  = (count_q == '0);
  assign srch_last = ((idx_cnt + CW'(1)) == count_q);
  assign del_last  = ((idx_cnt + CW'(2)) == count_q);
  assign type_hit  = (rd_entry_i.etype == word_q.event_type);
  assign add_later = (rd_entry_i.etime > word_q.event_time);
  assign adv_due   = (rd_entry_i.etime <= word_q.target_time);
  assign adv_more  = !is_empty && (num_q != NW'(toeq_pkg::MAX_RESULTS));

  assign in_stall_o = (state_q != toeq_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      toeq_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = toeq_pkg::ST_DECODE;
      end
      toeq_pkg::ST_DECODE: begin
        case (cmd)
          toeq_pkg::CMD_ADD: begin
            if (is_full)       state_d = toeq_pkg::ST_REPLY;
            else if (is_empty) state_d = toeq_pkg::ST_ADD_WR;
            else               state_d = toeq_pkg::ST_ADD_SCAN;
          end
          toeq_pkg::CMD_REMOVE, toeq_pkg::CMD_FIND: begin
            state_d = is_empty ? toeq_pkg::ST_REPLY : toeq_pkg::ST_SRCH;
          end
          toeq_pkg::CMD_POP: begin
            state_d = is_empty ? toeq_pkg::ST_REPLY : toeq_pkg::ST_POP_OUT;
          end
          toeq_pkg::CMD_ADVANCE: state_d = toeq_pkg::ST_ADV_RD;
          default:               state_d = toeq_pkg::ST_REPLY;
        endcase
      end
      toeq_pkg::ST_ADD_SCAN: begin
        if (!(add_later && idx_q != '0)) state_d = toeq_pkg::ST_ADD_WR;
      end
      toeq_pkg::ST_ADD_WR: state_d = toeq_pkg::ST_REPLY;
      toeq_pkg::ST_SRCH: begin
        if (type_hit) begin
          if (cmd == toeq_pkg::CMD_FIND || srch_last) state_d = toeq_pkg::ST_REPLY;
          else                                        state_d = toeq_pkg::ST_DEL;
        end else if (srch_last) begin
          state_d = toeq_pkg::ST_REPLY;
        end
      end
      toeq_pkg::ST_DEL: begin
        if (del_last) state_d = toeq_pkg::ST_REPLY;
      end
      toeq_pkg::ST_POP_OUT: state_d = toeq_pkg::ST_REPLY;
      toeq_pkg::ST_ADV_RD: begin
        state_d = adv_more ? toeq_pkg::ST_ADV_CHK : toeq_pkg::ST_ADV_END;
      end
      toeq_pkg::ST_ADV_CHK: begin
        if (!adv_due)                      state_d = toeq_pkg::ST_ADV_END;
        else if (!pend_v_q || slot_free_i) state_d = toeq_pkg::ST_ADV_RD;
      end
      toeq_pkg::ST_ADV_END: state_d = toeq_pkg::ST_REPLY;
      toeq_pkg::ST_REPLY: begin
        if (slot_free_i) state_d = toeq_pkg::ST_IDLE;
      end
      default: state_d = toeq_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM requests and result words
  always_comb begin
    word_d     = word_q;
    rep_d      = rep_q;
    head_d     = head_q;
    idx_d      = idx_q;
    count_d    = count_q;
    num_d      = num_q;
    pend_v_d   = pend_v_q;
    cur_time_d = cur_time_q;
    mem_req    = '0;
    emit       = 1'b0;
    emit_word  = rep_q;
    emit_word.last = 1'b1;
    case (state_q)
      toeq_pkg::ST_IDLE: begin
        if (in_valid_i) word_d = in_word_i;
      end
      toeq_pkg::ST_DECODE: begin
        rep_d = '0;
        rep_d.reply_kind = toeq_pkg::KIND_ACK;
        idx_d = '0;
        case (cmd)
          toeq_pkg::CMD_ADD: begin
            if (is_full) begin
              rep_d.dropped = 1'b1;
            end else if (!is_empty) begin
              // walk back from the tail
              idx_d         = count_m1[IW-1:0];
              mem_req.re    = 1'b1;
              mem_req.raddr = toeq_pkg::ring_addr(head_q, count_m1[IW-1:0]);
            end
          end
          toeq_pkg::CMD_REMOVE, toeq_pkg::CMD_FIND: begin
            if (is_empty) begin
              if (cmd == toeq_pkg::CMD_FIND) begin
                rep_d.reply_kind = toeq_pkg::KIND_FIND;
                rep_d.out_time   = '1;
              end
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = head_q;
            end
          end
          toeq_pkg::CMD_POP: begin
            if (is_empty) begin
              rep_d.reply_kind = toeq_pkg::KIND_NONE;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = head_q;
            end
          end
          toeq_pkg::CMD_ADVANCE: begin
            num_d    = '0;
            pend_v_d = 1'b0;
          end
          default: ;
        endcase
      end
      toeq_pkg::ST_ADD_SCAN: begin
        if (add_later) begin
          // shift this entry one place up, fetch the one below
          mem_req.we    = 1'b1;
          mem_req.waddr = toeq_pkg::ring_addr(head_q, idx_q + IW'(1));
          mem_req.wdata = rd_entry_i;
          if (idx_q != '0) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = toeq_pkg::ring_addr(head_q, idx_q - IW'(1));
            idx_d         = idx_q - IW'(1);
          end
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end
      toeq_pkg::ST_ADD_WR: begin
        mem_req.we          = 1'b1;
        mem_req.waddr       = toeq_pkg::ring_addr(head_q, idx_q);
        mem_req.wdata.etype = word_q.event_type;
        mem_req.wdata.etime = word_q.event_time;
        count_d             = count_q + CW'(1);
      end
      toeq_pkg::ST_SRCH: begin
        if (type_hit) begin
          rep_d.found = 1'b1;
          if (cmd == toeq_pkg::CMD_FIND) begin
            rep_d.reply_kind = toeq_pkg::KIND_FIND;
            rep_d.out_time   = rd_entry_i.etime;
          end else if (srch_last) begin
            count_d = count_m1;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = toeq_pkg::ring_addr(head_q, idx_q + IW'(1));
          end
        end else if (srch_last) begin
          if (cmd == toeq_pkg::CMD_FIND) begin
            rep_d.reply_kind = toeq_pkg::KIND_FIND;
            rep_d.out_time   = '1;
          end
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = toeq_pkg::ring_addr(head_q, idx_q + IW'(1));
          idx_d         = idx_q + IW'(1);
        end
      end
      toeq_pkg::ST_DEL: begin
        // close the gap: entry idx+1 moves down to idx
        mem_req.we    = 1'b1;
        mem_req.waddr = toeq_pkg::ring_addr(head_q, idx_q);
        mem_req.wdata = rd_entry_i;
        if (del_last) begin
          count_d = count_m1;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = toeq_pkg::ring_addr(head_q, idx_q + IW'(2));
          idx_d         = idx_q + IW'(1);
        end
      end
      toeq_pkg::ST_POP_OUT: begin
        rep_d.reply_kind = toeq_pkg::KIND_FIRED;
        rep_d.out_type   = rd_entry_i.etype;
        rep_d.out_time   = rd_entry_i.etime;
        head_d           = toeq_pkg::ring_addr(head_q, IW'(1));
        count_d          = count_m1;
        cur_time_d       = rd_entry_i.etime;
      end
      toeq_pkg::ST_ADV_RD: begin
        if (adv_more) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = head_q;
        end
      end
      toeq_pkg::ST_ADV_CHK: begin
        // hold one fired event back until the next one decides its last mark
        if (adv_due && (!pend_v_q || slot_free_i)) begin
          emit             = pend_v_q;
          emit_word.last   = 1'b0;
          rep_d            = '0;
          rep_d.reply_kind = toeq_pkg::KIND_FIRED;
          rep_d.out_type   = rd_entry_i.etype;
          rep_d.out_time   = rd_entry_i.etime;
          pend_v_d         = 1'b1;
          head_d           = toeq_pkg::ring_addr(head_q, IW'(1));
          count_d          = count_m1;
          num_d            = num_q + NW'(1);
        end
      end
      toeq_pkg::ST_ADV_END: begin
        if (!pend_v_q) begin
          rep_d            = '0;
          rep_d.reply_kind = toeq_pkg::KIND_NONE;
        end
        cur_time_d = word_q.target_time;
      end
      toeq_pkg::ST_REPLY: begin
        emit = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= toeq_pkg::ST_IDLE;
      head_q     <= '0;
      idx_q      <= '0;
      count_q    <= '0;
      num_q      <= '0;
      pend_v_q   <= 1'b0;
      cur_time_q <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      idx_q      <= idx_d;
      count_q    <= count_d;
      num_q      <= num_d;
      pend_v_q   <= pend_v_d;
      cur_time_q <= cur_time_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    rep_q  <= rep_d;
  end

  assign mem_req_o   = mem_req;
  assign emit_o      = emit;
  assign emit_word_o = emit_word;

  `TOEQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(toeq_pkg::QUEUE_DEPTH))
  `TOEQ_ASSERT(a_no_rw_clash, clk_i, rst_ni, !(mem_req.we && mem_req.re) || (mem_req.waddr != mem_req.raddr))
  `TOEQ_ASSERT(a_emit_states, clk_i, rst_ni, !emit || state_q == toeq_pkg::ST_REPLY || state_q == toeq_pkg::ST_ADV_CHK)
  `TOEQ_ASSERT_NEXT(a_adv_sets_now, clk_i, rst_ni, state_q == toeq_pkg::ST_ADV_END, cur_time_q == word_q.target_time)
  `TOEQ_ASSERT_NEXT(a_pop_shrinks, clk_i, rst_ni, state_q == toeq_pkg::ST_POP_OUT, count_q == $past(count_q) - CW'(1))

endmodule

// ===== rtl/time_ordered_event_queue_core.sv =====
// Sorted (type, time) event queue on a ring in one RAM, one command word at a time.
// Add walks back from the tail, shifting each later entry up until it meets an earlier one
// (refused when full); remove and find search from the head, and remove moves the entries
// behind the hit down one place; pop fires the head entry; advance fires due events in turn.
// The next word is taken in the cycle after the final result enters the output register;
// output stalls hold it back. Reset clears head, count and current time, not the entry RAM.
module time_ordered_event_queue_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  toeq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output toeq_pkg::out_word_t out_word_o
);

  toeq_pkg::mem_req_t  mem_req;
  toeq_pkg::entry_t    rd_entry;
  toeq_pkg::out_word_t emit_word;
  logic                emit;
  logic                slot_free;

  toeq_ram #(
    .Width($bits(toeq_pkg::entry_t)),
    .Depth(toeq_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rd_entry)
  );

  toeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .slot_free_i (slot_free),
    .emit_o      (emit),
    .emit_word_o (emit_word),
    .mem_req_o   (mem_req),
    .rd_entry_i  (rd_entry)
  );

  toeq_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .word_i      (emit_word),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .slot_free_o (slot_free)
  );

endmodule

// ===== tb/toeq_reply_checker.sv =====
// Reply checker for the time-ordered event queue: watches both channels, keeps its
// own sorted copy of the queue, predicts every reply word and compares field by field.
// Depends on toeq_pkg for the word types and the queue constants.
module toeq_reply_checker
  import toeq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned cmd_count_o,
  output int unsigned reply_count_o,
  output int unsigned fired_count_o,
  output int unsigned drop_count_o
);

  entry_t            sorted_events [QUEUE_DEPTH];
  int unsigned       event_count;
  logic [TIME_W-1:0] now_time;
  out_word_t         awaited_replies [$];

  function automatic out_word_t make_reply(kind_e kind, logic [TYPE_W-1:0] etype,
                                           logic [TIME_W-1:0] etime, logic hit,
                                           logic drop, logic fin);
    out_word_t r;
    r.reply_kind = kind;
    r.out_type   = etype;
    r.out_time   = etime;
    r.found      = hit;
    r.dropped    = drop;
    r.last       = fin;
    return r;
  endfunction

  // Earliest-queued slot of a type, or event_count when there is none.
  function automatic int unsigned first_of_type(logic [TYPE_W-1:0] etype);
    for (int unsigned i = 0; i < event_count; i++) begin
      if (sorted_events[i].etype == etype) begin
        return i;
      end
    end
    return event_count;
  endfunction

  task automatic drop_slot(int unsigned pos);
    for (int unsigned j = pos; j + 1 < event_count; j++) begin
      sorted_events[j] = sorted_events[j + 1];
    end
    event_count--;
  endtask

  task automatic predict_replies(in_word_t w);
    int unsigned pos;
    int unsigned fired;
    out_word_t   tail;
    logic        hit;
    case (w.cmd)
      CMD_ADD: begin
        if (event_count >= QUEUE_DEPTH) begin
          awaited_replies.push_back(make_reply(KIND_ACK, '0, '0, 1'b0, 1'b1, 1'b1));
          drop_count_o++;
        end else begin
          // Stable insert: go after every entry due at or before the new time.
          pos = event_count;
          while (pos > 0 && sorted_events[pos - 1].etime > w.event_time) begin
            sorted_events[pos] = sorted_events[pos - 1];
            pos--;
          end
          sorted_events[pos].etype = w.event_type;
          sorted_events[pos].etime = w.event_time;
          event_count++;
          awaited_replies.push_back(make_reply(KIND_ACK, '0, '0, 1'b0, 1'b0, 1'b1));
        end
      end
      CMD_REMOVE: begin
        // found reflects the search before the delete
        pos = first_of_type(w.event_type);
        hit = (pos < event_count);
        if (hit) begin
          drop_slot(pos);
        end
        awaited_replies.push_back(make_reply(KIND_ACK, '0, '0, hit, 1'b0, 1'b1));
      end
      CMD_FIND: begin
        pos = first_of_type(w.event_type);
        if (pos < event_count) begin
          awaited_replies.push_back(make_reply(KIND_FIND, '0, sorted_events[pos].etime,
                                               1'b1, 1'b0, 1'b1));
        end else begin
          awaited_replies.push_back(make_reply(KIND_FIND, '0, '1, 1'b0, 1'b0, 1'b1));
        end
      end
      CMD_POP: begin
        if (event_count == 0) begin
          awaited_replies.push_back(make_reply(KIND_NONE, '0, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          // Pop may move the current time backwards.
          now_time = sorted_events[0].etime;
          awaited_replies.push_back(make_reply(KIND_FIRED, sorted_events[0].etype,
                                               sorted_events[0].etime, 1'b0, 1'b0, 1'b1));
          fired_count_o++;
          drop_slot(0);
        end
      end
      CMD_ADVANCE: begin
        fired = 0;
        while (fired < MAX_RESULTS && event_count > 0 &&
               sorted_events[0].etime <= w.target_time) begin
          awaited_replies.push_back(make_reply(KIND_FIRED, sorted_events[0].etype,
                                               sorted_events[0].etime, 1'b0, 1'b0, 1'b0));
          drop_slot(0);
          fired++;
        end
        now_time = w.target_time;
        fired_count_o += fired;
        if (fired == 0) begin
          awaited_replies.push_back(make_reply(KIND_NONE, '0, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          tail = awaited_replies.pop_back();
          tail.last = 1'b1;
          awaited_replies.push_back(tail);
        end
      end
      default: begin
        awaited_replies.push_back(make_reply(KIND_ACK, '0, '0, 1'b0, 1'b0, 1'b1));
      end
    endcase
  endtask

  task automatic flag_mismatch(string what, logic [TIME_W-1:0] got, logic [TIME_W-1:0] want);
    $display("mismatch on reply %0d: %s got 0x%0h, want 0x%0h", reply_count_o, what,
             got, want);
    fail_count_o++;
  endtask

  task automatic check_reply(out_word_t got);
    out_word_t want;
    reply_count_o++;
    if (awaited_replies.size() == 0) begin
      flag_mismatch("reply with none awaited, out_time", got.out_time, '0);
    end else begin
      want = awaited_replies.pop_front();
      if (got.reply_kind !== want.reply_kind) begin
        flag_mismatch("reply_kind", TIME_W'(got.reply_kind), TIME_W'(want.reply_kind));
      end
      if (got.out_type !== want.out_type) begin
        flag_mismatch("out_type", TIME_W'(got.out_type), TIME_W'(want.out_type));
      end
      if (got.out_time !== want.out_time) begin
        flag_mismatch("out_time", got.out_time, want.out_time);
      end
      if (got.found !== want.found) begin
        flag_mismatch("found", TIME_W'(got.found), TIME_W'(want.found));
      end
      if (got.dropped !== want.dropped) begin
        flag_mismatch("dropped", TIME_W'(got.dropped), TIME_W'(want.dropped));
      end
      if (got.last !== want.last) begin
        flag_mismatch("last", TIME_W'(got.last), TIME_W'(want.last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_count   = 0;
      now_time      = '0;
      awaited_replies.delete();
      fail_count_o  = 0;
      pending_o     = 0;
      cmd_count_o   = 0;
      reply_count_o = 0;
      fired_count_o = 0;
      drop_count_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_reply(out_word_i);
      end
      if (in_valid_i && !in_stall_i) begin
        predict_replies(in_word_i);
        cmd_count_o++;
      end
      pending_o = awaited_replies.size();
    end
  end

endmodule

// ===== tb/time_ordered_event_queue_core_test.sv =====
// Top of the event queue testbench: clock, reset, directed and random command words,
// random idling on both channels, and the verdict.
// Depends on toeq_pkg, the block and toeq_reply_checker.
module time_ordered_event_queue_core_test;
  import toeq_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 410;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned FILL_ADDS     = QUEUE_DEPTH + 2;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        calm = 1'b0;
  int unsigned sent;
  int unsigned cycle_count;
  logic [TIME_W-1:0] time_base;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cmd_count;
  int unsigned reply_count;
  int unsigned fired_count;
  int unsigned drop_count;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  time_ordered_event_queue_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  toeq_reply_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .cmd_count_o   (cmd_count),
    .reply_count_o (reply_count),
    .fired_count_o (fired_count),
    .drop_count_o  (drop_count)
  );

  function automatic logic [TIME_W-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // Mostly a small pool so that find and remove hit often.
  function automatic logic [TYPE_W-1:0] pick_type();
    if ($urandom_range(0, 9) < 7) begin
      return TYPE_W'($urandom_range(0, 3));
    end
    return TYPE_W'($urandom_range(0, 31));
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return rnd64();
      default: return time_base + $urandom_range(0, 400);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] pick_target();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return time_base - $urandom_range(0, 200);
      2:       return rnd64();
      default: return time_base + $urandom_range(0, 400);
    endcase
  endfunction

  function automatic in_word_t command_word(logic [CMD_W-1:0] cmd, logic [TYPE_W-1:0] etype,
                                            logic [TIME_W-1:0] etime,
                                            logic [TIME_W-1:0] target);
    in_word_t w;
    w.cmd         = cmd;
    w.event_type  = etype;
    w.event_time  = etime;
    w.target_time = target;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Drop valid and hold off until every awaited reply has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : reply_sink
    int unsigned hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 5);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d replies awaited", cycle_count, pending);
    $display("FAIL time_ordered_event_queue_core");
    $finish;
  end

  initial begin : stimulus
    int unsigned      roll;
    int unsigned      scene;
    logic [CMD_W-1:0] cmd;
    bit               paused;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    sent      = 0;
    time_base = 64'd1000;
    paused    = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Empty queue: pop, advance, find and remove all miss.
    send_word(command_word(CMD_POP, 5'd31, rnd64(), rnd64()));
    send_word(command_word(CMD_ADVANCE, 5'd0, rnd64(), '1));
    send_word(command_word(CMD_FIND, 5'd31, rnd64(), rnd64()));
    send_word(command_word(CMD_REMOVE, 5'd0, rnd64(), rnd64()));
    // Extreme times and a tie at 100 to check stable ordering.
    send_word(command_word(CMD_ADD, 5'd0, '0, rnd64()));
    send_word(command_word(CMD_ADD, 5'd31, '1, rnd64()));
    send_word(command_word(CMD_ADD, 5'd5, 64'd100, rnd64()));
    send_word(command_word(CMD_ADD, 5'd6, 64'd100, rnd64()));
    send_word(command_word(CMD_ADD, 5'd5, 64'd50, rnd64()));
    send_word(command_word(CMD_FIND, 5'd5, rnd64(), rnd64()));
    send_word(command_word(CMD_REMOVE, 5'd5, rnd64(), rnd64()));
    send_word(command_word(CMD_FIND, 5'd5, rnd64(), rnd64()));
    send_word(command_word(CMD_FIND, 5'd31, rnd64(), rnd64()));
    send_word(command_word(CMD_SPARE_LO, 5'd31, '1, '1));
    send_word(command_word(CMD_SPARE_MID, 5'd0, '0, '0));
    send_word(command_word(CMD_SPARE_HI, 5'd9, rnd64(), rnd64()));
    send_word(command_word(CMD_POP, 5'd0, rnd64(), rnd64()));
    send_word(command_word(CMD_ADVANCE, 5'd0, rnd64(), 64'd100));
    // Advance backwards finds nothing due.
    send_word(command_word(CMD_ADVANCE, 5'd0, rnd64(), '0));
    send_word(command_word(CMD_POP, 5'd0, rnd64(), rnd64()));
    // Pop behind the current time.
    send_word(command_word(CMD_ADD, 5'd9, 64'd10, rnd64()));
    send_word(command_word(CMD_POP, 5'd0, rnd64(), rnd64()));
    send_word(command_word(CMD_POP, 5'd0, rnd64(), rnd64()));
    send_word(command_word(CMD_ADD, 5'd17, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA));
    send_word(command_word(CMD_ADVANCE, 5'd10, 64'h5555_5555_5555_5555,
                           64'hAAAA_AAAA_AAAA_AAAA));

    while (sent < RANDOM_ITEMS) begin
      calm  = ($urandom_range(0, 3) == 0);
      scene = $urandom_range(0, 9);
      if (scene < 6) begin
        repeat (20) begin
          roll = $urandom_range(0, 99);
          if (roll < 40) begin
            cmd = CMD_ADD;
          end else if (roll < 55) begin
            cmd = CMD_FIND;
          end else if (roll < 68) begin
            cmd = CMD_REMOVE;
          end else if (roll < 78) begin
            cmd = CMD_POP;
          end else if (roll < 95) begin
            cmd = CMD_ADVANCE;
            time_base = time_base + $urandom_range(0, 150);
          end else begin
            cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
          end
          send_word(command_word(cmd, pick_type(), pick_time(), pick_target()));
        end
      end else if (scene < 8) begin
        // Fill past full, fire part of it, then flush everything.
        repeat (FILL_ADDS) begin
          send_word(command_word(CMD_ADD, pick_type(), time_base + $urandom_range(0, 60),
                                 rnd64()));
        end
        send_word(command_word(CMD_ADVANCE, pick_type(), rnd64(), time_base + 30));
        send_word(command_word(CMD_ADVANCE, pick_type(), rnd64(), '1));
        time_base = time_base + 100;
      end else begin
        repeat (16) begin
          roll = $urandom_range(0, 99);
          cmd  = (roll < 40) ? CMD_ADD : (roll < 70) ? CMD_FIND : CMD_REMOVE;
          send_word(command_word(cmd, TYPE_W'($urandom_range(0, 3)), pick_time(),
                                 rnd64()));
        end
      end
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("ran %0d commands over every code with %0d replies checked", cmd_count,
             reply_count);
    $display("%0d events fired by pop or advance, %0d adds refused on a full queue",
             fired_count, drop_count);
    if (fail_count == 0) begin
      $display("PASS time_ordered_event_queue_core");
    end else begin
      $display("FAIL time_ordered_event_queue_core");
    end
    $finish;
  end

endmodule
